// ===== rtl/klr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package klr_pkg;

  // default geometry
  localparam int KEY_COUNT_DEF   = 25;
  localparam int STORE_DEPTH_DEF = 4096;

  // register field widths
  localparam int TIMEOUT_W = 16;
  localparam int LIMIT_W   = 13;
  localparam int CFG_W     = 16;

  // register reset values
  localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = 16'd250;
  localparam logic [LIMIT_W-1:0]   RECORD_LIMIT_RST = 13'd3750;

  // register indexes
  localparam logic CFG_IDLE_TIMEOUT = 1'b0;
  localparam logic CFG_RECORD_LIMIT = 1'b1;

  // tone divider geometry
  localparam int RELOAD_W      = 12;
  localparam int COMPARE_W     = 11;
  localparam int TONE_ROM_SIZE = 24;
  localparam int TONE_IDX_W    = 5;

  // tone settings handed to the output stage
  typedef struct packed {
    logic                 enable;
    logic [RELOAD_W-1:0]  reload;
    logic [COMPARE_W-1:0] compare;
  } tone_t;

  // reload divider at 1 MHz for each note
  function automatic logic [RELOAD_W-1:0] tone_rom(input logic [TONE_IDX_W-1:0] idx);
    logic [RELOAD_W-1:0] val;
    case (idx)
      5'd0:    val = 12'd2862;
      5'd1:    val = 12'd2702;
      5'd2:    val = 12'd2550;
      5'd3:    val = 12'd2407;
      5'd4:    val = 12'd2272;
      5'd5:    val = 12'd2144;
      5'd6:    val = 12'd2024;
      5'd7:    val = 12'd1910;
      5'd8:    val = 12'd1803;
      5'd9:    val = 12'd1702;
      5'd10:   val = 12'd1606;
      5'd11:   val = 12'd1516;
      5'd12:   val = 12'd1431;
      5'd13:   val = 12'd1350;
      5'd14:   val = 12'd1275;
      5'd15:   val = 12'd1203;
      5'd16:   val = 12'd1135;
      5'd17:   val = 12'd1072;
      5'd18:   val = 12'd1011;
      5'd19:   val = 12'd955;
      5'd20:   val = 12'd901;
      5'd21:   val = 12'd850;
      5'd22:   val = 12'd803;
      default: val = 12'd757;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/klr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module klr_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/klr_tone.sv =====
`timescale 1ns / 1ps
`default_nettype none

module klr_tone #(
  parameter int KEY_COUNT = 25,
  parameter int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1
) (
  input  wire logic [KEY_W-1:0] key,
  output klr_pkg::tone_t        tone
);
  import klr_pkg::*;

  localparam logic [KEY_W-1:0] SILENCE = KEY_W'(KEY_COUNT - 1);

  logic [6:0]            key_ext;
  logic [TONE_IDX_W-1:0] idx;
  logic [RELOAD_W-1:0]   reload;

  // clamp keys beyond the table to its last entry
  always_comb begin
    key_ext = 7'(key);
    if (key_ext >= 7'(TONE_ROM_SIZE)) begin
      idx = TONE_IDX_W'(TONE_ROM_SIZE - 1);
    end else begin
      idx = key_ext[TONE_IDX_W-1:0];
    end
  end

  // silence gives a zero divider
  always_comb begin
    tone.enable  = (key != SILENCE);
    reload       = tone.enable ? tone_rom(idx) : '0;
    tone.reload  = reload;
    tone.compare = reload[RELOAD_W-1:1];
  end

endmodule

`default_nettype wire

// ===== rtl/keypad_melody_recorder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake               payload
// in        input      in_valid / in_stall     in_key_matrix
// out       output     out_valid / out_stall   out_tone_*, out_is_*, out_sleep_request
// cfg       input      cfg_we                  cfg_index, cfg_wdata
//
// Two-stage pipeline, one tick per cycle sustained while the output is not stalled.
// Stage one updates the sequencer and issues the melody store write or
// playback read; stage two takes the registered read data, settles the
// sounding key, the idle count and the tone divider into the output register.
// Reset is synchronous and clears all control state; the store is not cleared.
// A stalled output holds the pipeline and stalls the input.

module keypad_melody_recorder #(
  parameter int KEY_COUNT   = klr_pkg::KEY_COUNT_DEF,
  parameter int STORE_DEPTH = klr_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [KEY_COUNT-1:0]           in_key_matrix,

  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_tone_enable,
  output logic                                out_tone_update,
  output logic [klr_pkg::RELOAD_W-1:0]        out_tone_reload,
  output logic [klr_pkg::COMPARE_W-1:0]       out_tone_compare,
  output logic                                out_is_playing,
  output logic                                out_is_recording,
  output logic                                out_sleep_request,

  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [klr_pkg::CFG_W-1:0]      cfg_wdata
);
  import klr_pkg::*;

  localparam int KEY_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LEN_W  = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W  = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;
  localparam int SIL    = KEY_COUNT - 1;
  localparam logic [KEY_W-1:0] SILENCE = KEY_W'(SIL);

  // configuration registers
  logic [TIMEOUT_W-1:0] idle_timeout_r;
  logic [LIMIT_W-1:0]   record_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= IDLE_TIMEOUT_RST;
      record_limit_r <= RECORD_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_RECORD_LIMIT: record_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_r, out_valid_r;
  logic advance;
  logic accept;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  // sequencer state
  logic             mode_before_r, record_r, play_r;
  logic [LEN_W-1:0] pos_r, len_r;
  logic             mode_before_nxt, record_nxt, play_nxt;
  logic [LEN_W-1:0] pos_nxt, len_nxt;

  // stage one: decode the snapshot and step the sequencer
  logic [KEY_W-1:0] a_key;
  logic             a_mode;
  logic             a_wr, a_rd;
  logic [CMP_W-1:0] limit;

  always_comb begin
    a_key = SILENCE;
    for (int i = 0; i < SIL; i++) begin
      if (in_key_matrix[i]) begin
        a_key = KEY_W'(i);
      end
    end
    a_mode = in_key_matrix[SIL];
  end

  always_comb begin
    if (CMP_W'(record_limit_r) > CMP_W'(STORE_DEPTH)) begin
      limit = CMP_W'(STORE_DEPTH);
    end else begin
      limit = CMP_W'(record_limit_r);
    end
  end

  always_comb begin
    mode_before_nxt = mode_before_r;
    record_nxt      = record_r;
    play_nxt        = play_r;
    pos_nxt         = pos_r;
    len_nxt         = len_r;
    a_wr            = 1'b0;
    a_rd            = 1'b0;

    // mode release ends recording or toggles playback
    if (a_mode != mode_before_r) begin
      mode_before_nxt = a_mode;
      if (!a_mode) begin
        if (record_r) begin
          record_nxt = 1'b0;
        end else if (!play_r) begin
          if (len_r != '0) begin
            play_nxt = 1'b1;
            pos_nxt  = '0;
          end
        end else begin
          play_nxt = 1'b0;
        end
      end
    end

    // mode plus a note starts a new recording
    if (a_mode && !record_nxt && a_key != SILENCE) begin
      record_nxt = 1'b1;
      len_nxt    = '0;
    end

    // store one code per tick up to the limit
    if (record_nxt && CMP_W'(len_nxt) < limit) begin
      a_wr    = 1'b1;
      len_nxt = len_nxt + 1'b1;
    end

    // playback reads the next code unless a live note aborts it
    if (play_nxt) begin
      if (a_key != SILENCE) begin
        play_nxt = 1'b0;
      end else begin
        a_rd    = 1'b1;
        pos_nxt = pos_nxt + 1'b1;
        if (pos_nxt >= len_nxt) begin
          play_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_before_r <= 1'b0;
      record_r      <= 1'b0;
      play_r        <= 1'b0;
      pos_r         <= '0;
      len_r         <= '0;
    end else if (accept) begin
      mode_before_r <= mode_before_nxt;
      record_r      <= record_nxt;
      play_r        <= play_nxt;
      pos_r         <= pos_nxt;
      len_r         <= len_nxt;
    end
  end

  // melody store; write and read at the length and position before their increment
  logic [KEY_W-1:0] rd_key;
  logic [LEN_W-1:0] wr_len;
  logic [LEN_W-1:0] rd_pos;

  assign wr_len = (a_mode && !record_r && a_key != SILENCE && !(a_mode != mode_before_r &&
                  !a_mode)) ? '0 : len_r;
  assign rd_pos = pos_nxt - 1'b1;

  klr_ram #(
    .WIDTH (KEY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && a_wr),
    .waddr (wr_len[ADDR_W-1:0]),
    .wdata (a_key),
    .re    (accept && a_rd),
    .raddr (rd_pos[ADDR_W-1:0]),
    .rdata (rd_key)
  );

  // stage one register
  logic [KEY_W-1:0] s1_key_r;
  logic             s1_mode_r, s1_rd_r, s1_play_r, s1_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key_r  <= a_key;
      s1_mode_r <= a_mode;
      s1_rd_r   <= a_rd;
      s1_play_r <= play_nxt;
      s1_rec_r  <= record_nxt;
    end
  end

  // stage two: sounding key, idle count, tone divider
  logic [KEY_W-1:0]     key_before_r, key_before_nxt;
  logic [TIMEOUT_W-1:0] idle_r, idle_nxt;
  logic [TIMEOUT_W:0]   idle_inc;
  logic [KEY_W-1:0]     b_key;
  logic                 b_update, b_sleep;
  tone_t                b_tone;

  always_comb begin
    b_key = s1_key_r;
    if (s1_rd_r) begin
      b_key = (rd_key > SILENCE) ? SILENCE : rd_key;
    end
    b_update       = (b_key != key_before_r);
    key_before_nxt = b_key;
  end

  always_comb begin
    idle_inc = {1'b0, idle_r} + 1'b1;
    b_sleep  = 1'b0;
    if (b_key != SILENCE || s1_mode_r || s1_play_r) begin
      idle_nxt = '0;
    end else if (idle_inc >= {1'b0, idle_timeout_r}) begin
      idle_nxt = '0;
      b_sleep  = 1'b1;
    end else begin
      idle_nxt = idle_inc[TIMEOUT_W-1:0];
    end
  end

  klr_tone #(
    .KEY_COUNT (KEY_COUNT)
  ) u_tone (
    .key  (b_key),
    .tone (b_tone)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_before_r <= SILENCE;
      idle_r       <= '0;
    end else if (advance) begin
      key_before_r <= key_before_nxt;
      idle_r       <= idle_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tone_enable   <= b_tone.enable;
      out_tone_update   <= b_update;
      out_tone_reload   <= b_tone.reload;
      out_tone_compare  <= b_tone.compare;
      out_is_playing    <= s1_play_r;
      out_is_recording  <= s1_rec_r;
      out_sleep_request <= b_sleep;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== verif/keypad_melody_recorder_tb.sv =====
`timescale 1ns / 1ps

module keypad_melody_recorder_tb;
  import klr_pkg::*;

  localparam int NOTE_KEYS     = 24;
  localparam int SILENCE       = 24;
  localparam int MELODY_DEPTH  = 4096;
  localparam int DRAIN_CYCLES  = 6;
  localparam int PHASE_COUNT   = 7;
  localparam int PHASE_TICKS   = 58;
  localparam int CYCLE_LIMIT   = 200000;
  localparam logic [24:0] MODE_BIT = 25'h1000000;

  // divider per note, 1 MHz timer
  localparam logic [RELOAD_W-1:0] NOTE_DIVIDER [NOTE_KEYS] = '{
    12'd2862, 12'd2702, 12'd2550, 12'd2407, 12'd2272, 12'd2144, 12'd2024,
    12'd1910, 12'd1803, 12'd1702, 12'd1606, 12'd1516, 12'd1431, 12'd1350,
    12'd1275, 12'd1203, 12'd1135, 12'd1072, 12'd1011,
    12'd955, 12'd901, 12'd850, 12'd803, 12'd757
  };

  typedef struct packed {
    logic                 enable;
    logic                 update;
    logic [RELOAD_W-1:0]  reload;
    logic [COMPARE_W-1:0] compare;
    logic                 playing;
    logic                 recording;
    logic                 sleep;
  } tone_result_t;

  typedef struct packed {
    logic [24:0]  matrix;
    logic         typed;
    tone_result_t want;
  } dir_row_t;

  localparam int DIR_COUNT = 22;

  // directed ticks, typed expectations only where obvious
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{25'h0000000, 1'b1, '{1'b0, 1'b0, 12'd0, 11'd0, 1'b0, 1'b0, 1'b0}},
    '{25'h1000000, 1'b0, '0},   // mode alone
    '{25'h0000000, 1'b0, '0},   // release with empty melody, no playback
    '{25'h0000001, 1'b1, '{1'b1, 1'b1, 12'd2862, 11'd1431, 1'b0, 1'b0, 1'b0}},
    '{25'h0800001, 1'b1, '{1'b1, 1'b1, 12'd757, 11'd378, 1'b0, 1'b0, 1'b0}},
    '{25'h0FFFFFF, 1'b1, '{1'b1, 1'b0, 12'd757, 11'd378, 1'b0, 1'b0, 1'b0}},
    '{25'h1FFFFFF, 1'b0, '0},   // all keys with mode, recording starts
    '{25'h1000020, 1'b0, '0},
    '{25'h1000000, 1'b0, '0},   // recorded pause
    '{25'h1001000, 1'b0, '0},
    '{25'h0000000, 1'b0, '0},   // mode released, recording ends
    '{25'h1000000, 1'b0, '0},
    '{25'h0000000, 1'b0, '0},   // playback starts
    '{25'h0000000, 1'b0, '0},
    '{25'h0000400, 1'b0, '0},   // live key aborts playback
    '{25'h1000000, 1'b0, '0},
    '{25'h0000000, 1'b0, '0},
    '{25'h1000000, 1'b0, '0},
    '{25'h0000000, 1'b0, '0},   // release while playing stops playback
    '{25'h0000000, 1'b0, '0},
    '{25'h1000001, 1'b0, '0},   // lowest key starts a new recording
    '{25'h0000000, 1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [24:0]          in_key_matrix = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_tone_enable;
  logic                 out_tone_update;
  logic [RELOAD_W-1:0]  out_tone_reload;
  logic [COMPARE_W-1:0] out_tone_compare;
  logic                 out_is_playing;
  logic                 out_is_recording;
  logic                 out_sleep_request;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_IDLE_TIMEOUT;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  keypad_melody_recorder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_key_matrix     (in_key_matrix),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tone_enable   (out_tone_enable),
    .out_tone_update   (out_tone_update),
    .out_tone_reload   (out_tone_reload),
    .out_tone_compare  (out_tone_compare),
    .out_is_playing    (out_is_playing),
    .out_is_recording  (out_is_recording),
    .out_sleep_request (out_sleep_request),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sequencer shadow state
  logic [4:0]   melody_mem [MELODY_DEPTH];
  int           seq_length = 0;
  int           seq_play_pos = 0;
  logic         seq_playing = 1'b0;
  logic         seq_recording = 1'b0;
  logic         seq_mode_before = 1'b0;
  int           sounding_key = SILENCE;
  int           idle_ticks = 0;
  int           idle_timeout = int'(IDLE_TIMEOUT_RST);
  int           rec_limit = int'(RECORD_LIMIT_RST);

  tone_result_t expected_tones [$];
  tone_result_t seen_tone;
  tone_result_t want_tone;
  int           ticks_sent = 0;
  int           results_seen = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           src_idle_pct = 0;
  int           sink_stall_pct = 0;

  // one tick of the sequencer
  function automatic tone_result_t predict_tick(input logic [24:0] m);
    tone_result_t r;
    int key;
    int lim;
    logic mode;
    r = '0;
    key = SILENCE;
    for (int i = 0; i < NOTE_KEYS; i++)
      if (m[i]) key = i;
    mode = m[24];

    // mode release ends a recording or toggles playback
    if (mode != seq_mode_before) begin
      seq_mode_before = mode;
      if (!mode) begin
        if (seq_recording) begin
          seq_recording = 1'b0;
        end else if (!seq_playing) begin
          if (seq_length > 0) begin
            seq_playing = 1'b1;
            seq_play_pos = 0;
          end
        end else begin
          seq_playing = 1'b0;
        end
      end
    end

    if (mode && !seq_recording && key != SILENCE) begin
      seq_recording = 1'b1;
      seq_length = 0;
    end

    // store one code per tick until full
    if (seq_recording) begin
      lim = (rec_limit > MELODY_DEPTH) ? MELODY_DEPTH : rec_limit;
      if (seq_length < lim) begin
        melody_mem[seq_length] = 5'(key);
        seq_length++;
      end
    end

    // playback, aborted by any live key
    if (seq_playing) begin
      if (key != SILENCE) begin
        seq_playing = 1'b0;
      end else begin
        key = int'(melody_mem[seq_play_pos]);
        if (key > SILENCE) key = SILENCE;
        seq_play_pos++;
        if (seq_play_pos >= seq_length) seq_playing = 1'b0;
      end
    end

    if (key != sounding_key) begin
      sounding_key = key;
      r.update = 1'b1;
    end
    if (sounding_key != SILENCE) begin
      r.enable  = 1'b1;
      r.reload  = NOTE_DIVIDER[sounding_key];
      r.compare = r.reload[RELOAD_W-1:1];
    end

    // idle run toward standby
    if (key != SILENCE || mode || seq_playing) begin
      idle_ticks = 0;
    end else begin
      idle_ticks++;
      if (idle_ticks >= idle_timeout) begin
        r.sleep = 1'b1;
        idle_ticks = 0;
      end
    end

    r.playing   = seq_playing;
    r.recording = seq_recording;
    return r;
  endfunction

  function automatic logic [24:0] random_notes();
    int k;
    logic [24:0] low;
    k = $urandom_range(NOTE_KEYS - 1);
    low = 25'($urandom()) & ((25'd1 << k) - 25'd1);
    if ($urandom_range(1) == 0) low = '0;
    return (25'd1 << k) | low;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s on result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
    mismatch_count++;
  endtask

  task automatic check_tone(input tone_result_t got, input tone_result_t want);
    if (got.enable !== want.enable)
      report_mismatch("tone_enable", int'(got.enable), int'(want.enable));
    if (got.update !== want.update)
      report_mismatch("tone_update", int'(got.update), int'(want.update));
    if (got.reload !== want.reload)
      report_mismatch("tone_reload", int'(got.reload), int'(want.reload));
    if (got.compare !== want.compare)
      report_mismatch("tone_compare", int'(got.compare), int'(want.compare));
    if (got.playing !== want.playing)
      report_mismatch("is_playing", int'(got.playing), int'(want.playing));
    if (got.recording !== want.recording)
      report_mismatch("is_recording", int'(got.recording), int'(want.recording));
    if (got.sleep !== want.sleep)
      report_mismatch("sleep_request", int'(got.sleep), int'(want.sleep));
  endtask

  // input transfer; called and left at a falling edge
  task automatic send_tick(input logic [24:0] m, input logic typed, input tone_result_t want);
    tone_result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_key_matrix <= m;
    predicted = predict_tick(m);
    expected_tones.push_back(typed ? want : predicted);
    ticks_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_plain(input logic [24:0] m);
    send_tick(m, 1'b0, '0);
  endtask

  // wait until every tick has produced its result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_tones.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_registers(input int timeout, input int limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDLE_TIMEOUT;
    cfg_wdata <= CFG_W'(timeout);
    idle_timeout = timeout;
    @(negedge clk);
    cfg_index <= CFG_RECORD_LIMIT;
    cfg_wdata <= CFG_W'(limit);
    rec_limit = limit & 16'h1FFF;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one random usage pattern
  task automatic run_sequence();
    int kind;
    int n;
    int k;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // record: optional mode lead-in, notes and pauses, release
      n = $urandom_range(2);
      repeat (n) send_plain(MODE_BIT);
      send_plain(MODE_BIT | random_notes());
      n = $urandom_range(1, 8);
      repeat (n) send_plain(MODE_BIT | (($urandom_range(1) == 1) ? random_notes() : 25'd0));
      send_plain(($urandom_range(4) == 0) ? random_notes() : 25'd0);
    end else if (kind < 65) begin
      // playback, then run out, abort or stop
      send_plain(MODE_BIT);
      send_plain('0);
      n = $urandom_range(seq_length + 1);
      repeat (n) send_plain('0);
      k = $urandom_range(2);
      if (k == 1) begin
        send_plain(random_notes());
      end else if (k == 2) begin
        send_plain(MODE_BIT);
        send_plain('0);
      end
    end else if (kind < 82) begin
      n = $urandom_range(1, 20);
      repeat (n) send_plain('0);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_plain(25'($urandom()));
    end
  endtask

  // receiver stalls
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < sink_stall_pct);

  // result transfer check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_tone = '{out_tone_enable, out_tone_update, out_tone_reload, out_tone_compare,
                    out_is_playing, out_is_recording, out_sleep_request};
      if (expected_tones.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want_tone = expected_tones.pop_front();
        check_tone(seen_tone, want_tone);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int timeout;
    int limit;
    int target;
    for (int i = 0; i < MELODY_DEPTH; i++) melody_mem[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed ticks at reset settings
    for (int r = 0; r < DIR_COUNT; r++)
      send_tick(DIR_ROWS[r].matrix, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    drain_results();

    // random phases over register settings and idling patterns
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        1: begin timeout = 1;     limit = 1;    end
        2: begin timeout = 65535; limit = 4096; end
        3: begin timeout = 4;     limit = 5;    end
        4: begin timeout = 12;    limit = 3;    end
        5: begin timeout = $urandom_range(1, 40); limit = $urandom_range(1, 16); end
        6: begin timeout = int'(IDLE_TIMEOUT_RST); limit = int'(RECORD_LIMIT_RST); end
        default: begin timeout = int'(IDLE_TIMEOUT_RST); limit = int'(RECORD_LIMIT_RST); end
      endcase
      if (p > 0) set_registers(timeout, limit);
      case (p % 4)
        1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
        3: begin src_idle_pct = 23; sink_stall_pct = 23; end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      target = ticks_sent + PHASE_TICKS;
      while (ticks_sent < target) run_sequence();
      drain_results();
    end

    if (expected_tones.size() != 0)
      report_mismatch("results still pending", 0, expected_tones.size());
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/klr_pkg.sv
rtl/klr_ram.sv
rtl/klr_tone.sv
rtl/keypad_melody_recorder.sv
verif/keypad_melody_recorder_tb.sv
